@@ hw/rtl/isl_pkg.sv @@
// Shared types and codes for the indexed sequential list core.
// Used by the entry store, the controller, the output stage and the top level; depends on nothing.
package isl_pkg;

  // Request codes carried on the input tuser field.
  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_LOCATE = 3'd2,
    REQ_READ   = 3'd3,
    REQ_CLEAR  = 3'd4
  } isl_req_t;

  // Controller sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_SHIFT,
    ST_INS_PUT,
    ST_DEL_SHIFT,
    ST_LOCATE,
    ST_READ,
    ST_DONE
  } isl_state_t;

  // Outcome codes on the status field.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam int unsigned POS_W  = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned LEN_W  = 6;

  // One result word as handed from the controller to the output stage.
  typedef struct packed {
    logic                     status;
    logic [POS_W-1:0]         index;
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]         list_length;
    logic                     list_empty;
  } isl_result_t;

endpackage

@@ hw/rtl/isl_mem.sv @@
// Entry store of the list: one write port, one read port, registered read data.
// Depends on isl_pkg for the data width.
module isl_mem
  import isl_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/isl_ctrl.sv @@
// Request sequencer: decodes a request, walks the entry store and forms the result.
// Depends on isl_pkg; drives the ports of isl_mem.
module isl_ctrl
  import isl_pkg::*;
#(
  parameter int unsigned CAPACITY = 32,
  parameter int unsigned AW       = 5,
  parameter int unsigned CW       = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_req,
  input  logic [POS_W-1:0]  in_pos,
  input  logic [DATA_W-1:0] in_val,
  output logic              res_valid,
  input  logic              res_ready,
  output isl_result_t       res,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [DATA_W-1:0] mem_wdata,
  output logic [AW-1:0]     mem_raddr,
  input  logic [DATA_W-1:0] mem_rdata
);

  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

  isl_state_t        state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     ptr, ptr_next;
  logic              pend, pend_next;
  logic [AW-1:0]     paddr, paddr_next;
  logic [POS_W-1:0]  pos_q, pos_q_next;
  logic [DATA_W-1:0] val_q, val_q_next;
  logic              status, status_next;
  logic [POS_W-1:0]  index, index_next;
  logic [DATA_W-1:0] rdv, rdv_next;

  logic [XW-1:0] pos_x, cnt_x, posq_x, ptr_x;
  logic          full, found;

  assign pos_x  = XW'(in_pos);
  assign cnt_x  = XW'(count);
  assign posq_x = XW'(pos_q);
  assign ptr_x  = XW'(ptr);
  assign full   = (count == CW'(CAPACITY));
  assign found  = pend && (mem_rdata == val_q);

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    ptr    <= ptr_next;
    paddr  <= paddr_next;
    pos_q  <= pos_q_next;
    val_q  <= val_q_next;
    status <= status_next;
    index  <= index_next;
    rdv    <= rdv_next;
  end

  // Sequencer: a pending read in a shift state is written back one slot over.
  always_comb begin
    state_next  = state;
    count_next  = count;
    ptr_next    = ptr;
    pend_next   = 1'b0;
    paddr_next  = paddr;
    pos_q_next  = pos_q;
    val_q_next  = val_q;
    status_next = status;
    index_next  = index;
    rdv_next    = rdv;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = paddr;
    mem_wdata   = mem_rdata;
    mem_raddr   = AW'(ptr);

    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        mem_raddr = AW'(in_pos);
        if (in_valid) begin
          pos_q_next  = in_pos;
          val_q_next  = in_val;
          status_next = STATUS_FAIL;
          index_next  = '0;
          rdv_next    = '0;
          state_next  = ST_DONE;
          case (isl_req_t'(in_req))
            REQ_INSERT: begin
              if (!full && !(pos_x > cnt_x)) begin
                ptr_next   = count;
                state_next = ST_INS_SHIFT;
              end
            end
            REQ_DELETE: begin
              if (pos_x < cnt_x) begin
                ptr_next   = CW'(in_pos) + CW'(1);
                state_next = ST_DEL_SHIFT;
              end
            end
            REQ_LOCATE: begin
              ptr_next   = '0;
              state_next = ST_LOCATE;
            end
            REQ_READ: begin
              if (pos_x < cnt_x) begin
                state_next = ST_READ;
              end
            end
            REQ_CLEAR: begin
              count_next  = '0;
              status_next = STATUS_OK;
            end
            default: begin
              status_next = STATUS_FAIL;
            end
          endcase
        end
      end

      // Move entries up, from the top of the list down to the insert position.
      ST_INS_SHIFT: begin
        mem_we = pend;
        if (ptr_x > posq_x) begin
          mem_raddr  = AW'(ptr - CW'(1));
          pend_next  = 1'b1;
          paddr_next = AW'(ptr);
          ptr_next   = ptr - CW'(1);
        end else begin
          state_next = ST_INS_PUT;
        end
      end

      // Drain the last moved entry, then place the new one.
      ST_INS_PUT: begin
        if (pend) begin
          mem_we = 1'b1;
        end else begin
          mem_we      = 1'b1;
          mem_waddr   = AW'(pos_q);
          mem_wdata   = val_q;
          count_next  = count + CW'(1);
          status_next = STATUS_OK;
          index_next  = pos_q;
          state_next  = ST_DONE;
        end
      end

      // Move entries down, from just above the deleted slot to the top.
      ST_DEL_SHIFT: begin
        mem_we = pend;
        if (ptr < count) begin
          pend_next  = 1'b1;
          paddr_next = AW'(ptr - CW'(1));
          ptr_next   = ptr + CW'(1);
        end else if (!pend) begin
          count_next  = count - CW'(1);
          status_next = STATUS_OK;
          state_next  = ST_DONE;
        end
      end

      // Scan upward; a match on the returning word ends the search.
      ST_LOCATE: begin
        if (found) begin
          status_next = STATUS_OK;
          index_next  = POS_W'(paddr);
          state_next  = ST_DONE;
        end else if (ptr < count) begin
          pend_next  = 1'b1;
          paddr_next = AW'(ptr);
          ptr_next   = ptr + CW'(1);
        end else if (!pend) begin
          state_next = ST_DONE;
        end
      end

      // Read data for the position requested in the idle cycle.
      ST_READ: begin
        status_next = STATUS_OK;
        rdv_next    = mem_rdata;
        state_next  = ST_DONE;
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Result word.
  assign res.status      = status;
  assign res.index       = index;
  assign res.read_value  = rdv;
  assign res.list_length = LEN_W'(count);
  assign res.list_empty  = (count == '0);

endmodule

@@ hw/rtl/isl_out.sv @@
// Output register of the list core: holds one result word for the master side.
// Depends on isl_pkg for the result type.
module isl_out
  import isl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        res_valid,
  output logic        res_ready,
  input  isl_result_t res,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,
  output logic        m_tuser
);

  isl_result_t held;

  assign res_ready = !m_tvalid || m_tready;

  // Valid flag of the held word.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  // Payload is loaded whenever the slot is free or being emptied.
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      held <= res;
    end
  end

  assign m_tdata = {4'b0000, held.list_empty, held.list_length, held.read_value, held.index};
  assign m_tuser = held.status;

endmodule

@@ hw/rtl/indexed_sequential_list_core.sv @@
// Indexed sequential list: a bounded ordered list of signed 32-bit entries.
// Each request word inserts, deletes, locates, reads or clears and yields one
// result word on the master side.
//
// Slave side: s_tuser is the request code, s_tdata the position and value.
// Master side: m_tuser is the status, m_tdata the index, the read value,
// the list length and the empty flag.
// One request is worked on at a time; s_tready is high only while the
// sequencer is idle. The shift and the search walk the entry store one
// entry per cycle through its one read port and one write port.
// A finished result waits in the output register, so a new request is taken
// while the receiver stalls; if a second result is ready before the first
// is taken, the sequencer holds it and takes no further request.
// Reset empties the list and drops any result in flight; the entry store
// itself is not cleared, since only written entries are ever read.
module indexed_sequential_list_core
  import isl_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position [4:0], value [36:5], zero pad
  input  logic [2:0]  s_tuser,   // req_type [2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // index [4:0], read_value [36:5], list_length [42:37],
                                 // list_empty [43], zero pad
  output logic        m_tuser    // status [0]
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;
  logic              res_valid, res_ready;
  isl_result_t       res;

  isl_mem #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  isl_ctrl #(
    .CAPACITY(CAPACITY),
    .AW      (AW),
    .CW      (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_req   (s_tuser),
    .in_pos   (s_tdata[4:0]),
    .in_val   (s_tdata[36:5]),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  isl_out u_out (
    .clk      (clk),
    .rst      (rst),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

@@ hw/rtl/isl_checker.sv @@
// Port-level checks for the indexed sequential list core, and their binding.
// Sees only the top-level ports; depends on nothing else.
module isl_checker #(
  parameter int unsigned CAPACITY = 32
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser
);

  // A stalled result word holds still.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // One request at a time: the cycle after a take, no further request is taken.
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in work");

  // A rejected request reports neither an index nor a read value.
  a_rej: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[36:0] == 37'd0)
    else $error("rejected result carries data");

  // The empty flag agrees with the length, and the length stays within capacity.
  a_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (CAPACITY > 63) ||
      ((m_tdata[43] == (m_tdata[42:37] == 6'd0)) && (m_tdata[42:37] <= CAPACITY)))
    else $error("list length and empty flag disagree");

endmodule

bind indexed_sequential_list_core isl_checker #(.CAPACITY(CAPACITY)) u_isl_checker (.*);
